// ----- hw/rtl/ssi_pkg.sv -----
// Shared widths, constants and stage side-band types for the segment/sphere crossing pipeline.
package ssi_pkg;

  localparam int FRAC_BITS = 16;
  localparam int COORD_W   = 24;
  localparam int RAD_W     = 23;
  localparam int DIFF_W    = COORD_W + 1;
  localparam int PROD_W    = 2 * DIFF_W;
  localparam int RR_W      = 2 * RAD_W;
  localparam int A_W       = PROD_W;
  localparam int B_W       = PROD_W + 2;
  localparam int C_W       = PROD_W + 1;
  localparam int BABS_W    = B_W - 1;
  localparam int CABS_W    = PROD_W;
  localparam int B_SPL     = (BABS_W + 1) / 2;
  localparam int B_HI_W    = BABS_W - B_SPL;
  localparam int AC_SPL    = A_W / 2;
  localparam int AC_HI_W   = A_W - AC_SPL;
  localparam int BB_W      = 2 * BABS_W;
  localparam int AC_W      = A_W + CABS_W;
  localparam int DISC_W    = BB_W + 2;
  localparam int ROOT_W    = DISC_W / 2;
  localparam int N_W       = ROOT_W + 2;
  localparam int M_W       = N_W - 1;
  localparam int DEN_W     = A_W + 1;
  localparam int Q_W       = FRAC_BITS + 2;
  localparam int RES_W     = FRAC_BITS + 1;
  localparam int DIV_ST    = FRAC_BITS + 1;

  localparam logic [Q_W-1:0] Q_ONE = Q_W'(1) << FRAC_BITS;

  typedef struct packed {
    logic signed [COORD_W-1:0] center_x;
    logic signed [COORD_W-1:0] center_y;
    logic signed [COORD_W-1:0] center_z;
    logic        [RAD_W-1:0]   sphere_radius;
    logic signed [COORD_W-1:0] start_x;
    logic signed [COORD_W-1:0] start_y;
    logic signed [COORD_W-1:0] start_z;
    logic signed [COORD_W-1:0] end_x;
    logic signed [COORD_W-1:0] end_y;
    logic signed [COORD_W-1:0] end_z;
  } in_item_t;

  typedef struct packed {
    logic [RES_W-1:0] crossing_fraction;
  } out_item_t;

  typedef struct packed {
    logic        [A_W-1:0] a;
    logic signed [B_W-1:0] b;
    logic                  live;
  } sq_side_t;

  typedef struct packed {
    logic neg;
    logic rej;
    logic live;
  } dv_side_t;

endpackage

// ----- hw/rtl/ssi_if.sv -----
// Valid/ready channel interfaces for query beats and result beats.
interface ssi_in_if import ssi_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source(output valid, data, input ready);
  modport sink(input valid, data, output ready);
endinterface

interface ssi_out_if import ssi_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source(output valid, data, input ready);
  modport sink(input valid, data, output ready);
endinterface

// ----- hw/rtl/segment_sphere_intersection.sv -----
// Top level of the segment/sphere crossing pipeline.
// Takes one query beat per cycle and returns one crossing_fraction beat for each, in order;
// 7 stages form a, b, c and the discriminant (wide multiplies split into partial products of
// at most 26 by 26 bits), 52 square-root stages resolve one root bit each, 2 stages form the
// two root numerators and their magnitudes, and 17 divider stages per root produce the integer
// part and 16 fraction bits; the last stage is the output register. When the output beat is
// held the whole pipeline holds, so nothing is lost or repeated.
module segment_sphere_intersection import ssi_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  ssi_in_if.sink    in_ch,
  ssi_out_if.source out_ch
);

  logic en;
  logic s1_vld_r, s2_vld_r, s3_vld_r, s4_vld_r, s5_vld_r, s6_vld_r, s7_vld_r;
  logic r0_vld_r, r1_vld_r, out_vld_r;

  logic signed [DIFF_W-1:0] s1_dx_r, s1_dy_r, s1_dz_r, s1_fx_r, s1_fy_r, s1_fz_r;
  logic        [RAD_W-1:0]  s1_r_r;

  logic signed [PROD_W-1:0] s2_xx_r, s2_yy_r, s2_zz_r, s2_xf_r, s2_yf_r, s2_zf_r;
  logic signed [PROD_W-1:0] s2_fx_r, s2_fy_r, s2_fz_r;
  logic        [RR_W-1:0]   s2_rr_r;

  logic        [A_W-1:0]    s3_a_r;
  logic signed [B_W-1:0]    s3_b_r;
  logic signed [C_W-1:0]    s3_c_r;
  logic        [A_W-1:0]    ff_sum;
  logic signed [B_W-1:0]    b_sum;

  logic        [A_W-1:0]    s4_a_r;
  logic signed [B_W-1:0]    s4_b_r;
  logic        [BABS_W-1:0] s4_babs_r;
  logic        [CABS_W-1:0] s4_cabs_r;
  logic                     s4_cneg_r;

  logic        [A_W-1:0]    s5_a_r;
  logic signed [B_W-1:0]    s5_b_r;
  logic                     s5_cneg_r;
  logic [2*B_SPL-1:0]       s5_bll_r;
  logic [B_SPL+B_HI_W-1:0]  s5_blh_r;
  logic [2*B_HI_W-1:0]      s5_bhh_r;
  logic [2*AC_SPL-1:0]      s5_all_r;
  logic [AC_SPL+AC_HI_W-1:0] s5_alh_r, s5_ahl_r;
  logic [2*AC_HI_W-1:0]     s5_ahh_r;

  logic        [A_W-1:0]    s6_a_r;
  logic signed [B_W-1:0]    s6_b_r;
  logic                     s6_cneg_r;
  logic        [BB_W-1:0]   s6_bb_r;
  logic        [AC_W-1:0]   s6_ac_r;

  logic        [DISC_W-1:0] s7_disc_r;
  sq_side_t                 s7_side_r;
  logic        [BB_W-1:0]   fourac;

  logic                     sq_valid;
  logic        [ROOT_W-1:0] sq_root;
  sq_side_t                 sq_side;
  logic signed [N_W-1:0]    root_s, b_s;

  logic signed [N_W-1:0]    r0_n1_r, r0_n2_r;
  logic        [A_W-1:0]    r0_a_r;
  logic                     r0_live_r;

  logic        [M_W-1:0]    r1_m1_r, r1_m2_r;
  logic        [DEN_W-1:0]  r1_den_r;
  dv_side_t                 r1_s1_r, r1_s2_r;

  logic                     dv1_valid, dv2_valid;
  logic        [Q_W-1:0]    dv1_q, dv2_q;
  logic        [DEN_W-1:0]  dv1_rem, dv2_rem;
  dv_side_t                 dv1_side, dv2_side;
  logic        [RES_W:0]    pick1, pick2;
  logic        [RES_W-1:0]  frac_nxt;
  logic        [RES_W-1:0]  out_frac_r;

  assign en          = !out_vld_r || out_ch.ready;
  assign in_ch.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
      s4_vld_r <= 1'b0;
      s5_vld_r <= 1'b0;
      s6_vld_r <= 1'b0;
      s7_vld_r <= 1'b0;
      r0_vld_r <= 1'b0;
      r1_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else if (en) begin
      s1_vld_r <= in_ch.valid;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
      s4_vld_r <= s3_vld_r;
      s5_vld_r <= s4_vld_r;
      s6_vld_r <= s5_vld_r;
      s7_vld_r <= s6_vld_r;
      r0_vld_r <= sq_valid;
      r1_vld_r <= r0_vld_r;
      out_vld_r <= dv1_valid;
    end
  end

  always_comb begin
    ff_sum = A_W'($unsigned(s2_fx_r)) + A_W'($unsigned(s2_fy_r)) + A_W'($unsigned(s2_fz_r));
    b_sum  = B_W'(s2_xf_r) + B_W'(s2_yf_r) + B_W'(s2_zf_r);
    fourac = {s6_ac_r, 2'b00};
    root_s = $signed(N_W'(sq_root));
    b_s    = N_W'(sq_side.b);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_dx_r <= DIFF_W'(in_ch.data.end_x) - DIFF_W'(in_ch.data.start_x);
      s1_dy_r <= DIFF_W'(in_ch.data.end_y) - DIFF_W'(in_ch.data.start_y);
      s1_dz_r <= DIFF_W'(in_ch.data.end_z) - DIFF_W'(in_ch.data.start_z);
      s1_fx_r <= DIFF_W'(in_ch.data.start_x) - DIFF_W'(in_ch.data.center_x);
      s1_fy_r <= DIFF_W'(in_ch.data.start_y) - DIFF_W'(in_ch.data.center_y);
      s1_fz_r <= DIFF_W'(in_ch.data.start_z) - DIFF_W'(in_ch.data.center_z);
      s1_r_r  <= in_ch.data.sphere_radius;

      s2_xx_r <= s1_dx_r * s1_dx_r;
      s2_yy_r <= s1_dy_r * s1_dy_r;
      s2_zz_r <= s1_dz_r * s1_dz_r;
      s2_xf_r <= s1_dx_r * s1_fx_r;
      s2_yf_r <= s1_dy_r * s1_fy_r;
      s2_zf_r <= s1_dz_r * s1_fz_r;
      s2_fx_r <= s1_fx_r * s1_fx_r;
      s2_fy_r <= s1_fy_r * s1_fy_r;
      s2_fz_r <= s1_fz_r * s1_fz_r;
      s2_rr_r <= s1_r_r * s1_r_r;

      s3_a_r <= A_W'($unsigned(s2_xx_r)) + A_W'($unsigned(s2_yy_r)) + A_W'($unsigned(s2_zz_r));
      s3_b_r <= b_sum <<< 1;
      s3_c_r <= $signed({1'b0, ff_sum}) - $signed(C_W'(s2_rr_r));

      s4_a_r    <= s3_a_r;
      s4_b_r    <= s3_b_r;
      s4_babs_r <= s3_b_r[B_W-1] ? BABS_W'(-s3_b_r) : BABS_W'(s3_b_r);
      s4_cabs_r <= s3_c_r[C_W-1] ? CABS_W'(-s3_c_r) : CABS_W'(s3_c_r);
      s4_cneg_r <= s3_c_r[C_W-1];

      s5_a_r    <= s4_a_r;
      s5_b_r    <= s4_b_r;
      s5_cneg_r <= s4_cneg_r;
      s5_bll_r  <= s4_babs_r[B_SPL-1:0] * s4_babs_r[B_SPL-1:0];
      s5_blh_r  <= s4_babs_r[B_SPL-1:0] * s4_babs_r[BABS_W-1:B_SPL];
      s5_bhh_r  <= s4_babs_r[BABS_W-1:B_SPL] * s4_babs_r[BABS_W-1:B_SPL];
      s5_all_r  <= s4_a_r[AC_SPL-1:0] * s4_cabs_r[AC_SPL-1:0];
      s5_alh_r  <= s4_a_r[AC_SPL-1:0] * s4_cabs_r[CABS_W-1:AC_SPL];
      s5_ahl_r  <= s4_a_r[A_W-1:AC_SPL] * s4_cabs_r[AC_SPL-1:0];
      s5_ahh_r  <= s4_a_r[A_W-1:AC_SPL] * s4_cabs_r[CABS_W-1:AC_SPL];

      s6_a_r    <= s5_a_r;
      s6_b_r    <= s5_b_r;
      s6_cneg_r <= s5_cneg_r;
      s6_bb_r   <= (BB_W'(s5_bhh_r) << (2 * B_SPL)) + (BB_W'(s5_blh_r) << (B_SPL + 1))
                 + BB_W'(s5_bll_r);
      s6_ac_r   <= (AC_W'(s5_ahh_r) << (2 * AC_SPL)) + (AC_W'(s5_alh_r) << AC_SPL)
                 + (AC_W'(s5_ahl_r) << AC_SPL) + AC_W'(s5_all_r);

      s7_disc_r <= s6_cneg_r ? DISC_W'(s6_bb_r) + DISC_W'(fourac)
                             : DISC_W'(s6_bb_r) - DISC_W'(fourac);
      s7_side_r.a    <= s6_a_r;
      s7_side_r.b    <= s6_b_r;
      s7_side_r.live <= (s6_cneg_r || fourac <= s6_bb_r) && (s6_a_r != '0);

      r0_n1_r   <= root_s - b_s;
      r0_n2_r   <= -b_s - root_s;
      r0_a_r    <= sq_side.a;
      r0_live_r <= sq_side.live;

      r1_m1_r       <= r0_n1_r[N_W-1] ? M_W'(-r0_n1_r) : M_W'(r0_n1_r);
      r1_m2_r       <= r0_n2_r[N_W-1] ? M_W'(-r0_n2_r) : M_W'(r0_n2_r);
      r1_den_r      <= {r0_a_r, 1'b0};
      r1_s1_r.neg   <= r0_n1_r[N_W-1];
      r1_s1_r.rej   <= 1'b0;
      r1_s1_r.live  <= r0_live_r;
      r1_s2_r.neg   <= r0_n2_r[N_W-1];
      r1_s2_r.rej   <= 1'b0;
      r1_s2_r.live  <= r0_live_r;

      out_frac_r <= frac_nxt;
    end
  end

  ssi_sqrt u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (s7_vld_r),
    .in_rad    (s7_disc_r),
    .in_side   (s7_side_r),
    .out_valid (sq_valid),
    .out_root  (sq_root),
    .out_side  (sq_side)
  );

  ssi_div u_div_hi (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (r1_vld_r),
    .in_mag    (r1_m1_r),
    .in_den    (r1_den_r),
    .in_side   (r1_s1_r),
    .out_valid (dv1_valid),
    .out_q     (dv1_q),
    .out_rem   (dv1_rem),
    .out_side  (dv1_side)
  );

  ssi_div u_div_lo (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (r1_vld_r),
    .in_mag    (r1_m2_r),
    .in_den    (r1_den_r),
    .in_side   (r1_s2_r),
    .out_valid (dv2_valid),
    .out_q     (dv2_q),
    .out_rem   (dv2_rem),
    .out_side  (dv2_side)
  );

  // {accept, value}
  function automatic logic [RES_W:0] pick_root(input logic [Q_W-1:0] q,
                                               input logic [DEN_W-1:0] rem,
                                               input dv_side_t side);
    logic acc;
    logic [RES_W-1:0] val;
    if (side.neg) begin
      acc = (q == '0) || (q == Q_W'(1) && rem == '0);
      val = '0;
    end else begin
      acc = (q <= Q_ONE) || (q == Q_ONE + Q_W'(1) && rem == '0);
      val = (q > Q_ONE) ? Q_ONE[RES_W-1:0] : q[RES_W-1:0];
    end
    return {acc && !side.rej, val};
  endfunction

  always_comb begin
    pick1 = pick_root(dv1_q, dv1_rem, dv1_side);
    pick2 = pick_root(dv2_q, dv2_rem, dv2_side);
    if (!dv1_side.live) begin
      frac_nxt = '0;
    end else if (pick1[RES_W]) begin
      frac_nxt = pick1[RES_W-1:0];
    end else if (pick2[RES_W]) begin
      frac_nxt = pick2[RES_W-1:0];
    end else begin
      frac_nxt = '0;
    end
  end

  assign out_ch.valid                  = out_vld_r;
  assign out_ch.data.crossing_fraction = out_frac_r;

  a_frac_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> out_ch.data.crossing_fraction <= Q_ONE[RES_W-1:0])
    else $error("crossing_fraction above one");

  a_lanes_step: assert property (@(posedge clk) disable iff (!rst_n)
    dv1_valid == dv2_valid)
    else $error("divider lanes out of step");

  a_accept_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> s1_vld_r)
    else $error("accepted beat lost at first stage");

endmodule

// ----- hw/rtl/ssi_sqrt.sv -----
// Pipelined integer square root, one root bit per stage, with side-band carried along.
module ssi_sqrt import ssi_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  logic [DISC_W-1:0] in_rad,
  input  sq_side_t          in_side,
  output logic              out_valid,
  output logic [ROOT_W-1:0] out_root,
  output sq_side_t          out_side
);

  logic              vld_r  [ROOT_W];
  logic [DISC_W-1:0] x_r    [ROOT_W];
  logic [DISC_W-1:0] y_r    [ROOT_W];
  sq_side_t          side_r [ROOT_W];

  for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
    localparam logic [DISC_W-1:0] BW = DISC_W'(1) << (DISC_W - 2 - 2 * k);
    logic [DISC_W-1:0] x_in, y_in, x_nxt, y_nxt;
    logic              v_in;
    sq_side_t          s_in;
    logic [DISC_W:0]   trial;

    if (k == 0) begin : g_first
      assign x_in = in_rad;
      assign y_in = '0;
      assign v_in = in_valid;
      assign s_in = in_side;
    end else begin : g_next
      assign x_in = x_r[k-1];
      assign y_in = y_r[k-1];
      assign v_in = vld_r[k-1];
      assign s_in = side_r[k-1];
    end

    always_comb begin
      trial = {1'b0, y_in} + {1'b0, BW};
      if ({1'b0, x_in} >= trial) begin
        x_nxt = x_in - trial[DISC_W-1:0];
        y_nxt = (y_in >> 1) + BW;
      end else begin
        x_nxt = x_in;
        y_nxt = y_in >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        x_r[k]    <= x_nxt;
        y_r[k]    <= y_nxt;
        side_r[k] <= s_in;
      end
    end
  end

  assign out_valid = vld_r[ROOT_W-1];
  assign out_root  = y_r[ROOT_W-1][ROOT_W-1:0];
  assign out_side  = side_r[ROOT_W-1];

endmodule

// ----- hw/rtl/ssi_div.sv -----
// Pipelined restoring divider for one root: integer part, then one fraction bit per stage.
module ssi_div import ssi_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_valid,
  input  logic [M_W-1:0]   in_mag,
  input  logic [DEN_W-1:0] in_den,
  input  dv_side_t         in_side,
  output logic             out_valid,
  output logic [Q_W-1:0]   out_q,
  output logic [DEN_W-1:0] out_rem,
  output dv_side_t         out_side
);

  logic             vld_r  [DIV_ST];
  logic [Q_W-1:0]   q_r    [DIV_ST];
  logic [DEN_W-1:0] rem_r  [DIV_ST];
  logic [DEN_W-1:0] den_r  [DIV_ST];
  dv_side_t         side_r [DIV_ST];

  logic [DEN_W:0]   den2;
  logic [Q_W-1:0]   q0_nxt;
  logic [DEN_W-1:0] rem0_nxt;
  dv_side_t         side0_nxt;

  always_comb begin
    den2      = {in_den, 1'b0};
    side0_nxt = in_side;
    side0_nxt.rej = in_mag > M_W'(den2);
    if (in_mag >= M_W'(den2)) begin
      q0_nxt   = Q_W'(2);
      rem0_nxt = DEN_W'(in_mag - M_W'(den2));
    end else if (in_mag >= M_W'(in_den)) begin
      q0_nxt   = Q_W'(1);
      rem0_nxt = DEN_W'(in_mag - M_W'(in_den));
    end else begin
      q0_nxt   = '0;
      rem0_nxt = DEN_W'(in_mag);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q_r[0]    <= q0_nxt;
      rem_r[0]  <= rem0_nxt;
      den_r[0]  <= in_den;
      side_r[0] <= side0_nxt;
    end
  end

  for (genvar j = 1; j < DIV_ST; j++) begin : g_frac
    logic [DEN_W:0]   rem2;
    logic [DEN_W-1:0] rem_nxt;
    logic             bit_nxt;

    always_comb begin
      rem2 = {rem_r[j-1], 1'b0};
      if (rem2 >= {1'b0, den_r[j-1]}) begin
        bit_nxt = 1'b1;
        rem_nxt = DEN_W'(rem2 - {1'b0, den_r[j-1]});
      end else begin
        bit_nxt = 1'b0;
        rem_nxt = rem2[DEN_W-1:0];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[j] <= 1'b0;
      end else if (en) begin
        vld_r[j] <= vld_r[j-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        q_r[j]    <= {q_r[j-1][Q_W-2:0], bit_nxt};
        rem_r[j]  <= rem_nxt;
        den_r[j]  <= den_r[j-1];
        side_r[j] <= side_r[j-1];
      end
    end
  end

  assign out_valid = vld_r[DIV_ST-1];
  assign out_q     = q_r[DIV_ST-1];
  assign out_rem   = rem_r[DIV_ST-1];
  assign out_side  = side_r[DIV_ST-1];

endmodule

// ----- verif/segment_sphere_intersection_test.sv -----
// Self-checking testbench for the segment/sphere crossing pipeline.
`timescale 1ns / 1ps

module segment_sphere_intersection_test;
  import ssi_pkg::*;

  localparam int N_RANDOM   = 1880;
  localparam int CALM_AFTER = 1650;
  localparam int ONE_Q16    = 32'h10000;

  typedef struct {
    in_item_t   item;
    logic       known;
    logic [16:0] fraction;
  } query_row_t;

  logic clk;
  logic rst_n;
  ssi_in_if  in_ch();
  ssi_out_if out_ch();

  segment_sphere_intersection dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .out_ch(out_ch)
  );

  logic [16:0] fraction_q[$];
  int errors = 0;
  bit calm = 0;

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("FAILURE");
    $finish;
  end

  function automatic bit try_root(longint n, longint unsigned den, output logic [16:0] res);
    longint unsigned m, q, rem;
    m = n < 0 ? 64'(-n) : 64'(n);
    res = 0;
    if (m > 2 * den) return 0;
    q = m / den;
    rem = m % den;
    for (int i = 0; i < FRAC_BITS; i++) begin
      rem = rem << 1;
      q = q << 1;
      if (rem >= den) begin
        rem -= den;
        q |= 1;
      end
    end
    if (n < 0) return (q == 0 || (q == 1 && rem == 0));
    if (q <= ONE_Q16 || (q == ONE_Q16 + 1 && rem == 0)) begin
      res = q > ONE_Q16 ? 17'(ONE_Q16) : 17'(q);
      return 1;
    end
    return 0;
  endfunction

  function automatic logic [16:0] crossing_of(in_item_t it);
    longint dx, dy, dz, fx, fy, fz, r, a, b, c, s;
    longint unsigned babs, cabs, cand;
    logic [127:0] bb, fourac, disc;
    logic [16:0] t;
    dx = longint'(it.end_x) - longint'(it.start_x);
    dy = longint'(it.end_y) - longint'(it.start_y);
    dz = longint'(it.end_z) - longint'(it.start_z);
    fx = longint'(it.start_x) - longint'(it.center_x);
    fy = longint'(it.start_y) - longint'(it.center_y);
    fz = longint'(it.start_z) - longint'(it.center_z);
    r = longint'({41'b0, it.sphere_radius});
    a = dx * dx + dy * dy + dz * dz;
    b = 2 * (dx * fx + dy * fy + dz * fz);
    c = fx * fx + fy * fy + fz * fz - r * r;
    if (a <= 0) return 0;
    babs = b < 0 ? 64'(-b) : 64'(b);
    cabs = c < 0 ? 64'(-c) : 64'(c);
    bb = 128'(babs) * 128'(babs);
    fourac = (128'(a) * 128'(cabs)) << 2;
    if (c < 0) disc = bb + fourac;
    else if (fourac <= bb) disc = bb - fourac;
    else return 0;
    s = 0;
    for (int k = 52; k >= 0; k--) begin
      cand = 64'(s) | (64'd1 << k);
      if (128'(cand) * 128'(cand) <= disc) s = longint'(cand);
    end
    if (try_root(s - b, 64'(2 * a), t)) return t;
    if (try_root(-b - s, 64'(2 * a), t)) return t;
    return 0;
  endfunction

  function automatic in_item_t make_query(int cx, int cy, int cz, int rad,
                                          int sx, int sy, int sz, int ex, int ey, int ez);
    in_item_t it;
    it.center_x = 24'(cx); it.center_y = 24'(cy); it.center_z = 24'(cz);
    it.sphere_radius = 23'(rad);
    it.start_x = 24'(sx); it.start_y = 24'(sy); it.start_z = 24'(sz);
    it.end_x = 24'(ex); it.end_y = 24'(ey); it.end_z = 24'(ez);
    return it;
  endfunction

  function automatic in_item_t random_query();
    in_item_t it;
    logic [255:0] raw;
    int cx, cy, cz, rad, span;
    case ($urandom_range(0, 9))
      0, 1: begin
        raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        it = raw[$bits(in_item_t)-1:0];
      end
      2: begin
        cx = $urandom_range(0, 255) - 128;
        it = make_query(cx, cx, cx, $urandom_range(0, 300), $urandom_range(0, 600) - 300,
                        $urandom_range(0, 600) - 300, 0, $urandom_range(0, 600) - 300, 0, 3);
      end
      default: begin
        span = 1 << $urandom_range(4, 22);
        rad = $urandom_range(1, span);
        cx = $urandom_range(0, 2 * span) - span;
        cy = $urandom_range(0, 2 * span) - span;
        cz = $urandom_range(0, 2 * span) - span;
        it = make_query(cx, cy, cz, rad,
                        cx + $urandom_range(0, 2 * rad) - rad,
                        cy + $urandom_range(0, 2 * rad) - rad,
                        cz + $urandom_range(0, 2 * rad) - rad,
                        cx + $urandom_range(0, 4 * rad) - 2 * rad,
                        cy + $urandom_range(0, 4 * rad) - 2 * rad,
                        cz + $urandom_range(0, 4 * rad) - 2 * rad);
      end
    endcase
    return it;
  endfunction

  task automatic report_mismatch(string what, logic [16:0] got, logic [16:0] want);
    $display("mismatch at %0t: %s got %0d want %0d", $realtime, what, got, want);
    errors++;
  endtask

  task automatic send_query(in_item_t it, logic known, logic [16:0] fraction);
    int gap;
    if (!calm && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 15);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= it;
    do @(posedge clk); while (!in_ch.ready);
    if (known && crossing_of(it) != fraction)
      report_mismatch("directed row prediction", crossing_of(it), fraction);
    fraction_q.push_back(known ? fraction : crossing_of(it));
  endtask

  // receive side: random stall bursts, none once calm
  initial begin
    int stall;
    stall = 0;
    out_ch.ready <= 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (out_ch.valid && out_ch.ready) begin
        if (fraction_q.size() == 0) begin
          report_mismatch("unexpected beat", out_ch.data.crossing_fraction, 17'd0);
        end else begin
          logic [16:0] want;
          want = fraction_q.pop_front();
          if (out_ch.data.crossing_fraction !== want)
            report_mismatch("crossing_fraction", out_ch.data.crossing_fraction, want);
        end
      end
      if (stall > 0) stall--;
      else if (!calm && $urandom_range(0, 7) == 0) stall = $urandom_range(1, 15);
      out_ch.ready <= (stall == 0);
    end
  end

  initial begin
    query_row_t rows[$];
    int lim;
    lim = 24'h7FFFFF;
    in_ch.valid <= 1'b0;
    in_ch.data <= '0;
    rst_n <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    rows.push_back('{make_query(0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, 0});
    rows.push_back('{make_query(5, 6, 7, lim, 100, 100, 100, 100, 100, 100), 1, 0});
    rows.push_back('{make_query(0, 0, 0, 65536, 0, 0, 0, 131072, 0, 0), 1, 32768});
    rows.push_back('{make_query(0, 0, 0, 65536, 0, 0, 0, 65536, 0, 0), 1, 17'(ONE_Q16)});
    rows.push_back('{make_query(0, 0, 0, 65536, 0, 0, 0, 0, 0, 65536), 1, 17'(ONE_Q16)});
    rows.push_back('{make_query(lim, lim, lim, 1, -lim-1, -lim-1, -lim-1, -lim-1, -lim-1, -lim),
                     1, 0});
    rows.push_back('{make_query(0, 0, 0, 65536, 65536, 0, 0, 131072, 0, 0), 1, 0});
    rows.push_back('{make_query(0, 0, 0, 65536, 131072, 0, 0, 262144, 0, 0), 1, 0});
    rows.push_back('{make_query(0, 0, 0, lim, -lim-1, -lim-1, -lim-1, lim, lim, lim), 0, 0});
    rows.push_back('{make_query(-lim-1, 0, lim, lim, lim, lim, lim, -lim-1, -lim-1, -lim-1),
                     0, 0});
    rows.push_back('{make_query(0, 0, 0, lim, 0, 0, 0, lim, lim, lim), 0, 0});
    rows.push_back('{make_query(0, 0, 0, 65536, -131072, 0, 0, 131072, 0, 0), 0, 0});
    rows.push_back('{make_query(0, 0, 0, 65536, 131072, 0, 0, -131072, 0, 0), 0, 0});
    rows.push_back('{make_query(0, 0, 0, 65536, 0, 65536, 0, 131072, 65536, 0), 0, 0});
    rows.push_back('{make_query(0, 0, 0, 65536, -65537, 0, 0, 65536, 0, 0), 0, 0});
    rows.push_back('{make_query(0, 0, 0, 65536, 0, 0, 0, 1, 0, 0), 1, 0});
    rows.push_back('{make_query(0, 0, 0, 1, 0, 0, 0, 1, 1, 1), 0, 0});
    rows.push_back('{make_query(3, -3, 3, 1000, 0, 0, 0, -lim-1, lim, 0), 0, 0});

    foreach (rows[i]) send_query(rows[i].item, rows[i].known, rows[i].fraction);

    // hold off until the pipeline drains
    in_ch.valid <= 1'b0;
    while (fraction_q.size() != 0) @(posedge clk);

    for (int n = 0; n < N_RANDOM; n++) begin
      if (n == CALM_AFTER) calm = 1;
      send_query(random_query(), 0, 0);
    end
    in_ch.valid <= 1'b0;
    while (fraction_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
